FILE: rtl/best_fit_heap_allocator_macros.svh
// assertion macros for the heap allocator
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define BFH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define BFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/bfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfh_pkg
// shared constants and types for the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfh_pkg;
  localparam int HeapBytes   = 4096;
  localparam int HeaderBytes = 8;
  localparam int FreeEntries = 512;
  localparam int SplitSlack  = HeaderBytes * 2;
  localparam int IdxW  = $clog2(FreeEntries);
  localparam int CntW  = $clog2(FreeEntries + 1);
  localparam int SizeW = $clog2(HeapBytes + 1);
  localparam int OffW  = $clog2(HeapBytes);
  localparam int NeedW = 14;

  // request operations
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [2:0] StAlloc   = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNofit   = 3'd2;
  localparam logic [2:0] StFreed   = 3'd3;
  localparam logic [2:0] StIgnored = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic scan_rd;    // issue read of scan index
    logic scan_adv;   // compare returned entry, advance
    logic hdr_rd;     // read header store at free start
    logic rem_step;   // one shift-down step of removal
    logic ins_prep;   // set up insert of split remainder or freed block
    logic ins_step;   // one shift-up step of insertion
    logic ins_put;    // write new entry and bump count
    logic hdr_wr;     // write header of the allocated block
  } bfh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic free_bad;
    logic scan_hit;     // entry at scan index fits
    logic scan_end;     // scan index reached count
    logic do_split;
    logic rem_done;
    logic table_full;
    logic ins_done;     // shifting reached insert position
  } bfh_sts_t;
endpackage

FILE: rtl/bfh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfh_datapath
// free table, header store and the scan/shift datapath
// ----------------------------------------------------------------------------
module bfh_datapath import bfh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bfh_cmd_t            cmd,
  output bfh_sts_t            sts,
  input  logic                in_cmd,
  input  logic [12:0]         in_req_size,
  input  logic [11:0]         in_block_addr,
  input  logic                in_ptr_present,
  output logic [11:0]         res_addr
);
  // free table memory: offset and size per entry
  logic [OffW+SizeW-1:0] tbl_mem [FreeEntries];
  logic [SizeW-1:0]      hdr_mem [HeapBytes];

  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  idx_r;       // scan / shift index
  logic             cmd_r;
  logic [NeedW-1:0] need_r;
  logic [12:0]      req_r;
  logic [11:0]      addr_r;
  logic             present_r;
  logic [OffW-1:0]  hit_off_r;
  logic [SizeW-1:0] hit_size_r;
  logic [OffW-1:0]  ins_off_r;
  logic [SizeW-1:0] ins_size_r;
  logic [OffW+SizeW-1:0] rd_q;
  logic [SizeW-1:0]      hdr_q;
  logic             tbl_we;
  logic [IdxW-1:0]  wr_idx;
  logic [OffW+SizeW-1:0] wr_data;
  logic [IdxW-1:0]  rd_idx;
  logic [SizeW-1:0] q_size;
  logic [OffW-1:0]  q_off;
  logic [NeedW:0]   split_lim;
  logic [OffW:0]    noff_wide;
  logic [11:0]      start;
  logic             shift_wr_r;
  logic [IdxW-1:0]  shift_idx_r;

  assign q_size = rd_q[SizeW-1:0];
  assign q_off  = rd_q[OffW+SizeW-1:SizeW];
  assign start  = addr_r - 12'(HeaderBytes);
  assign split_lim = {1'b0, need_r} + (NeedW+1)'(SplitSlack);
  assign noff_wide = {1'b0, hit_off_r} + (OffW+1)'(need_r);

  // read address: scan index, next entry in removal, last entry before
  // insert, or the entry two below the shift index, ready after next move
  always_comb begin
    rd_idx = idx_r[IdxW-1:0];
    if (cmd.ins_step) rd_idx = IdxW'(idx_r - 2'd2);
    else if (cmd.ins_prep) rd_idx = IdxW'(count_r - 1'b1);
    else if (cmd.rem_step) rd_idx = IdxW'(idx_r + 1'b1);
  end

  // table write port: new entry, shift up now, or delayed shift down
  always_comb begin
    tbl_we  = 1'b0;
    wr_idx  = idx_r[IdxW-1:0];
    wr_data = rd_q;
    if (cmd.ins_put) begin
      tbl_we  = 1'b1;
      wr_data = {ins_off_r, ins_size_r};
    end else if (cmd.ins_step) begin
      tbl_we = 1'b1;
    end else if (shift_wr_r) begin
      tbl_we = 1'b1;
      wr_idx = shift_idx_r;
    end
  end

  // removal writes the element read in the prior step; insert writes rd_q
  // one slot up in the same cycle it is compared
  always_ff @(posedge clk) begin
    rd_q <= tbl_mem[rd_idx];
    if (!rst_n) tbl_mem[0] <= {OffW'(0), SizeW'(HeapBytes)};
    else if (tbl_we) tbl_mem[wr_idx] <= wr_data;
  end

  // header store
  always_ff @(posedge clk) begin
    hdr_q <= hdr_mem[start[OffW-1:0]];
    if (!rst_n) hdr_mem[0] <= SizeW'(HeapBytes);
    else if (cmd.hdr_wr) begin
      hdr_mem[hit_off_r] <= SizeW'(need_r);
    end else if (cmd.ins_prep && cmd_r == CmdAlloc && !noff_wide[OffW]) begin
      hdr_mem[noff_wide[OffW-1:0]] <= SizeW'(hit_size_r - SizeW'(need_r));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= CntW'(1);
      idx_r      <= '0;
      shift_wr_r <= 1'b0;
    end else begin
      shift_wr_r <= 1'b0;
      if (cmd.load || cmd.scan_rd || cmd.hdr_rd) begin
        idx_r <= '0;
      end
      if (cmd.scan_adv) begin
        if (!sts.scan_hit) idx_r <= idx_r + 1'b1;
        else begin
          hit_off_r <= q_off;
          hit_size_r <= q_size;
        end
      end
      if (cmd.rem_step) begin
        if (sts.rem_done) count_r <= count_r - 1'b1;
        else begin
          shift_wr_r  <= 1'b1;
          shift_idx_r <= idx_r[IdxW-1:0];
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.ins_prep) begin
        idx_r <= count_r;
        if (cmd_r == CmdFree) begin
          ins_off_r  <= start[OffW-1:0];
          ins_size_r <= hdr_q;
        end else begin
          ins_off_r  <= noff_wide[OffW-1:0];
          ins_size_r <= hit_size_r - SizeW'(need_r);
        end
      end
      if (cmd.ins_step) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cmd.ins_put) count_r <= count_r + 1'b1;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_cmd;
      req_r     <= in_req_size;
      need_r    <= NeedW'(in_req_size) + NeedW'(HeaderBytes);
      addr_r    <= in_block_addr;
      present_r <= in_ptr_present;
    end
  end

  // insert stops just above the first entry, from the top, smaller than the new size, or at entry zero
  assign sts.is_free    = (cmd_r == CmdFree);
  assign sts.zero_req   = (req_r == '0);
  assign sts.free_bad   = !present_r || addr_r < 12'(HeaderBytes);
  assign sts.scan_end   = (idx_r >= count_r);
  assign sts.scan_hit   = !sts.scan_end && (NeedW'(q_size) >= need_r);
  assign sts.do_split   = {1'b0, NeedW'(hit_size_r)} > split_lim;
  assign sts.rem_done   = (idx_r + 1'b1 >= count_r);
  assign sts.table_full = (count_r >= CntW'(FreeEntries));
  assign sts.ins_done   = (idx_r == '0) || (q_size < ins_size_r);
  assign res_addr       = 12'(hit_off_r) + 12'(HeaderBytes);
endmodule

FILE: rtl/bfh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfh_ctrl
// sequencer for scan, removal, split and insertion
// ----------------------------------------------------------------------------
module bfh_ctrl import bfh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  output logic        busy,
  input  bfh_sts_t    sts,
  output bfh_cmd_t    cmd,
  output logic        done,
  output logic [2:0]  done_status,
  output logic        done_alloc
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC  = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_CMP  = 10'b0000001000,
    S_REM  = 10'b0000010000,
    S_HDR  = 10'b0000100000,
    S_PREP = 10'b0001000000,
    S_INS  = 10'b0010000000,
    S_PUT  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic alloc_r, alloc_nxt;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign done_status = st_r;
  assign done_alloc = alloc_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    alloc_nxt = alloc_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        alloc_nxt = 1'b0;
        if (sts.is_free) begin
          if (sts.free_bad) begin
            st_nxt = StIgnored; state_nxt = S_DONE;
          end else begin
            cmd.hdr_rd = 1'b1; st_nxt = StFreed; state_nxt = S_HDR;
          end
        end else if (sts.zero_req) begin
          st_nxt = StZero; state_nxt = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1; state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        cmd.scan_adv = 1'b1;
        if (sts.scan_end) begin
          st_nxt = StNofit; state_nxt = S_DONE;
        end else if (sts.scan_hit) begin
          st_nxt = StAlloc; alloc_nxt = 1'b1; state_nxt = S_REM;
        end else state_nxt = S_RD;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (sts.rem_done) state_nxt = S_HDR;
      end
      S_HDR: begin
        if (!sts.is_free) begin
          if (sts.do_split) begin
            cmd.hdr_wr = 1'b1; state_nxt = S_PREP;
          end else state_nxt = S_DONE;
        end else state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.ins_prep = 1'b1;
        state_nxt = sts.table_full ? S_DONE : S_INS;
      end
      S_INS: begin
        if (sts.ins_done) state_nxt = S_PUT;
        else cmd.ins_step = 1'b1;
      end
      S_PUT: begin
        cmd.ins_put = 1'b1; state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= StZero;
      alloc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      alloc_r <= alloc_nxt;
    end
  end
endmodule

FILE: rtl/best_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// best-fit byte heap allocator over a size-sorted free table
// ----------------------------------------------------------------------------
// usage
// - in_* carries one request: allocate (cmd 0) or free (cmd 1)
// - out_* returns one transaction per request: payload offset and status
// - one request is in work at a time; in_tready is low while busy
// - allocate scans the free table one entry per read and compare state pair,
//   then removes the hit by shifting the tail down one entry per cycle
// - split remainders and freed blocks are inserted by shifting entries up
//   one per cycle from the end of the table to the insert position
// - allocate time grows with the hit position and with the entries shifted
//   for removal and insertion, since the free table gives one read and
//   one write a cycle
// - a zero request or an ignored free goes from decode straight to done
// - reset leaves one free entry covering the whole heap
// - a finished result sits in the output register until out_tready; no new
//   request is accepted while it waits
// ----------------------------------------------------------------------------
module best_fit_heap_allocator import bfh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[0], req_size[13:1], block_addr[25:14], ptr_present[26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result_addr[11:0], status[14:12]
);
`include "best_fit_heap_allocator_macros.svh"

  bfh_cmd_t   cmd;
  bfh_sts_t   sts;
  logic       busy, done, done_alloc;
  logic [2:0] done_status;
  logic [11:0] res_addr;
  logic       in_fire;
  logic       out_full_r;
  logic [15:0] out_data_r;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !busy && !(out_full_r && !out_tready);

  bfh_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .busy, .sts, .cmd, .done, .done_status, .done_alloc
  );

  bfh_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_cmd(in_tdata[0]), .in_req_size(in_tdata[13:1]),
    .in_block_addr(in_tdata[25:14]), .in_ptr_present(in_tdata[26]),
    .res_addr
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (done) out_full_r <= 1'b1;
    else if (out_tready) out_full_r <= 1'b0;
    if (done) out_data_r <= {1'b0, done_status, done_alloc ? res_addr : 12'd0};
  end
  assign out_tvalid = out_full_r;
  assign out_tdata  = out_data_r;

  `BFH_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !in_tready, "accept while busy")
  `BFH_ASSERT_NEXT(a_done_valid, clk, rst_n, done, out_tvalid, "result not presented")
  `BFH_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tdata[14:12] <= StIgnored,
    "bad status")
endmodule
